/* rtl/lbbc_pkg.sv */
// Shared types, action codes and gamma curve for the LED breathing and blink controller.
package lbbc_pkg;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_BLINK = 2'd1,
      ACT_SLEEP = 2'd2,
      ACT_WAKE  = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] time_ticks;
      logic [15:0] blink_length;
      logic [15:0] blink_ticks;
   } req_word_type;

   typedef struct packed {
      logic [9:0] pwm_duty;
      logic       event_led;
   } rsp_word_type;

   localparam logic [15:0] BREATH_PERIOD_RESET = 16'd2048;
   localparam logic [15:0] BLINK_PER_DEFAULT   = 16'd100;
   localparam logic [15:0] BLINK_PER_MIN       = 16'd2;
   localparam logic [15:0] BLINK_LEN_DEFAULT   = 16'd5;
   localparam logic [9:0]  DUTY_FULL           = 10'h3FF;
   localparam logic [7:0]  LEVEL_TOP           = 8'hFF;
   localparam int          TIME_W              = 32;
   localparam int          STEP_SHIFT          = 9;

   localparam logic [7:0] GAMMA_ROM [64] = '{
      8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd6,
      8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd15,
      8'd16,  8'd17,  8'd19,  8'd20,  8'd22,  8'd24,  8'd26,  8'd28,
      8'd30,  8'd32,  8'd34,  8'd37,  8'd39,  8'd42,  8'd45,  8'd48,
      8'd51,  8'd54,  8'd57,  8'd61,  8'd65,  8'd68,  8'd72,  8'd77,
      8'd81,  8'd86,  8'd91,  8'd96,  8'd101, 8'd107, 8'd112, 8'd118,
      8'd125, 8'd131, 8'd138, 8'd145, 8'd152, 8'd160, 8'd168, 8'd176,
      8'd185, 8'd194, 8'd203, 8'd213, 8'd223, 8'd234, 8'd244, 8'd255
   };

endpackage

/* rtl/led_breathing_and_blink_controller.sv */
// Breathing system LED with gamma curve and counted event LED blink, one result per word.
// Tick word: 32 bit-serial divide steps, then the update, then the load into the output register.
// Blink, sleep and wakeup words: state updated on accept, then the load into the output register.
// One word at a time; the next word is taken as soon as the result sits in the output register,
// so a stalled result that blocks the load also holds off the next word.
// Synchronous active-high reset returns all LED state and the breathing period to defaults.
module led_breathing_and_blink_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lbbc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lbbc_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_wdata
);
   import lbbc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [4:0]   count_ff, count_in;
   logic [31:0]  time_sr_ff, time_sr_in;
   logic [6:0]   spc_div_ff, spc_div_in, spc_rem_ff, spc_rem_in;
   logic [15:0]  per_div_ff, per_div_in, per_rem_ff, per_rem_in;
   logic [14:0]  half_div_ff, half_div_in, half_rem_ff, half_rem_in;
   logic         half_q_ff, half_q_in;

   logic [15:0]  period_ff, period_in;
   logic         breathing_ff, breathing_in;
   logic [7:0]   level_ff, level_in;
   logic         rising_ff, rising_in;
   logic [9:0]   duty_ff, duty_in;
   logic [15:0]  blinks_ff, blinks_in;
   logic [15:0]  blink_per_ff, blink_per_in;
   logic         event_ff, event_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // divide step datapath
   logic [7:0]   spc_trial, spc_diff;
   logic [16:0]  per_trial, per_diff;
   logic [15:0]  half_trial, half_diff;
   logic         spc_ge, per_ge, half_ge;

   // divisor setup
   logic [6:0]   spc_raw;
   logic [15:0]  per_eff;
   logic [14:0]  half_raw;

   // gamma interpolation
   logic [1:0]   frac;
   logic [2:0]   weight_lo;
   logic [8:0]   level_inc;
   logic [7:0]   gamma_lo, gamma_hi;
   logic [10:0]  part_lo, part_hi, gamma_sum;
   logic [9:0]   gamma_duty;
   logic [7:0]   level_step;
   logic         do_step;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign spc_trial  = {spc_rem_ff, time_sr_ff[TIME_W-1]};
   assign spc_diff   = spc_trial - {1'b0, spc_div_ff};
   assign spc_ge     = (spc_trial >= {1'b0, spc_div_ff});
   assign per_trial  = {per_rem_ff, time_sr_ff[TIME_W-1]};
   assign per_diff   = per_trial - {1'b0, per_div_ff};
   assign per_ge     = (per_trial >= {1'b0, per_div_ff});
   assign half_trial = {half_rem_ff, time_sr_ff[TIME_W-1]};
   assign half_diff  = half_trial - {1'b0, half_div_ff};
   assign half_ge    = (half_trial >= {1'b0, half_div_ff});

   assign spc_raw  = period_ff[15:STEP_SHIFT];
   assign per_eff  = (blink_per_ff == 16'd0) ? 16'd1 : blink_per_ff;
   assign half_raw = per_eff[15:1];

   assign frac      = level_ff[1:0];
   assign weight_lo = 3'd4 - {1'b0, frac};
   assign level_inc = {1'b0, level_ff} + 9'd1;
   assign gamma_lo  = GAMMA_ROM[level_ff[7:2]];
   assign gamma_hi  = GAMMA_ROM[level_inc[7:2]];
   assign part_lo   = {3'd0, gamma_lo} * {8'd0, weight_lo};
   assign part_hi   = {3'd0, gamma_hi} * {9'd0, frac};
   assign gamma_sum = part_lo + part_hi;

   always_comb begin
      if (level_ff == 8'd0) begin
         gamma_duty = 10'd0;
      end else if (level_ff == LEVEL_TOP) begin
         gamma_duty = DUTY_FULL;
      end else begin
         gamma_duty = gamma_sum[9:0];
      end
   end

   assign do_step    = breathing_ff && (spc_rem_ff == 7'd0);
   assign level_step = rising_ff ? (level_ff + 8'd1) : (level_ff - 8'd1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      time_sr_in   = time_sr_ff;
      spc_div_in   = spc_div_ff;
      spc_rem_in   = spc_rem_ff;
      per_div_in   = per_div_ff;
      per_rem_in   = per_rem_ff;
      half_div_in  = half_div_ff;
      half_rem_in  = half_rem_ff;
      half_q_in    = half_q_ff;
      period_in    = period_ff;
      breathing_in = breathing_ff;
      level_in     = level_ff;
      rising_in    = rising_ff;
      duty_in      = duty_ff;
      blinks_in    = blinks_ff;
      blink_per_in = blink_per_ff;
      event_in     = event_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         period_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_word.action)
                  ACT_TICK: begin
                     time_sr_in  = req_word.time_ticks;
                     spc_div_in  = (spc_raw == 7'd0) ? 7'd1 : spc_raw;
                     per_div_in  = per_eff;
                     half_div_in = (half_raw == 15'd0) ? 15'd1 : half_raw;
                     spc_rem_in  = '0;
                     per_rem_in  = '0;
                     half_rem_in = '0;
                     count_in    = '0;
                     state_in    = ST_RUN;
                  end
                  ACT_BLINK: begin
                     blinks_in = (req_word.blink_length == 16'd0) ?
                                 BLINK_LEN_DEFAULT : req_word.blink_length;
                     if (req_word.blink_ticks == 16'd0) begin
                        blink_per_in = BLINK_PER_DEFAULT;
                     end else if (req_word.blink_ticks < BLINK_PER_MIN) begin
                        blink_per_in = BLINK_PER_MIN;
                     end else begin
                        blink_per_in = req_word.blink_ticks;
                     end
                     state_in = ST_FINISH;
                  end
                  ACT_SLEEP: begin
                     blinks_in    = '0;
                     event_in     = 1'b0;
                     breathing_in = 1'b0;
                     duty_in      = '0;
                     state_in     = ST_FINISH;
                  end
                  ACT_WAKE: begin
                     level_in     = '0;
                     breathing_in = 1'b1;
                     state_in     = ST_FINISH;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RUN: begin
            // one quotient bit per cycle, time shifted in MSB first
            time_sr_in  = {time_sr_ff[TIME_W-2:0], 1'b0};
            spc_rem_in  = spc_ge  ? spc_diff[6:0]   : spc_trial[6:0];
            per_rem_in  = per_ge  ? per_diff[15:0]  : per_trial[15:0];
            half_rem_in = half_ge ? half_diff[14:0] : half_trial[14:0];
            half_q_in   = half_ge;
            count_in    = count_ff + 5'd1;
            if (count_ff == 5'(TIME_W - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (do_step) begin
               duty_in  = gamma_duty;
               level_in = level_step;
               if (level_step == 8'd0 || level_step == LEVEL_TOP) begin
                  rising_in = !rising_ff;
               end
            end
            event_in = (blinks_ff != 16'd0) && !half_q_ff;
            if (per_rem_ff == 16'd0 && blinks_ff != 16'd0) begin
               blinks_in = blinks_ff - 16'd1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_word_in.pwm_duty  = duty_ff;
               rsp_word_in.event_led = event_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= BREATH_PERIOD_RESET;
         breathing_ff <= 1'b1;
         level_ff     <= '0;
         rising_ff    <= 1'b1;
         duty_ff      <= '0;
         blinks_ff    <= '0;
         blink_per_ff <= BLINK_PER_DEFAULT;
         event_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
         breathing_ff <= breathing_in;
         level_ff     <= level_in;
         rising_ff    <= rising_in;
         duty_ff      <= duty_in;
         blinks_ff    <= blinks_in;
         blink_per_ff <= blink_per_in;
         event_ff     <= event_in;
      end
   end

   always_ff @(posedge clock) begin
      time_sr_ff  <= time_sr_in;
      spc_div_ff  <= spc_div_in;
      spc_rem_ff  <= spc_rem_in;
      per_div_ff  <= per_div_in;
      per_rem_ff  <= per_rem_in;
      half_div_ff <= half_div_in;
      half_rem_ff <= half_rem_in;
      half_q_ff   <= half_q_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

/* rtl/lbbc_checker.sv */
// Port-level checks for the LED breathing and blink controller, bound to the top level.
module lbbc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input lbbc_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input lbbc_pkg::rsp_word_type rsp_word,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [15:0]           csr_wdata
);
   import lbbc_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new word taken while one is in flight");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a word in flight");

   a_sleep_dark: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_word.action == ACT_SLEEP && !rsp_valid) |=>
         ##1 (rsp_valid && rsp_word.pwm_duty == 10'd0 && !rsp_word.event_led))
      else $error("sleep did not turn both LEDs off");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result changed");

endmodule

bind led_breathing_and_blink_controller lbbc_checker u_lbbc_checker (.*);

/* tb/led_breathing_and_blink_controller_tb.sv */
// Self-checking testbench for the LED breathing and blink controller.
module led_breathing_and_blink_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lbbc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_wdata = '0;

   led_breathing_and_blink_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // LED controller state as the testbench sees it
   logic [15:0] breath_period;
   logic        breathe_on;
   logic [7:0]  level;
   logic        rising;
   logic [9:0]  duty_now;
   logic [15:0] blinks_left;
   logic [15:0] blink_per;
   logic        event_on;

   rsp_word_type expected_leds[$];
   rsp_word_type want;
   int           error_count = 0;
   int           rsp_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           hold_request = 0;
   int           hold_left = 0;
   logic [31:0]  time_now;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [9:0] duty_for_level(input logic [7:0] lvl);
      int unsigned r, lo, hi;
      if (lvl == 8'd0) return 10'd0;
      if (lvl == LEVEL_TOP) return DUTY_FULL;
      r = lvl[1:0];
      lo = GAMMA_ROM[lvl >> 2];
      hi = GAMMA_ROM[(int'(lvl) + 1) >> 2];
      return 10'((4 - r) * lo + r * hi);
   endfunction

   task automatic advance_led_state(input req_word_type w);
      logic [31:0] spacing, per, half;
      case (w.action)
         ACT_TICK: begin
            if (breathe_on) begin
               spacing = 32'(breath_period >> STEP_SHIFT);
               if (spacing == 0) spacing = 1;
               if (w.time_ticks % spacing == 0) begin
                  duty_now = duty_for_level(level);
                  level = rising ? level + 8'd1 : level - 8'd1;
                  if (level == 8'd0 || level == LEVEL_TOP) rising = !rising;
               end
            end
            per = 32'(blink_per);
            if (per == 0) per = 1;
            half = per / 2;
            if (half == 0) half = 1;
            event_on = (blinks_left != 0) && (((w.time_ticks / half) & 1) == 0);
            if (w.time_ticks % per == 0 && blinks_left != 0) blinks_left = blinks_left - 16'd1;
         end
         ACT_BLINK: begin
            blinks_left = (w.blink_length != 0) ? w.blink_length : BLINK_LEN_DEFAULT;
            per = 32'(w.blink_ticks);
            if (per == 0) per = 32'(BLINK_PER_DEFAULT);
            if (per < 32'(BLINK_PER_MIN)) per = 32'(BLINK_PER_MIN);
            blink_per = per[15:0];
         end
         ACT_SLEEP: begin
            blinks_left = 16'd0;
            event_on = 1'b0;
            breathe_on = 1'b0;
            duty_now = 10'd0;
         end
         default: begin
            level = 8'd0;
            breathe_on = 1'b1;
         end
      endcase
      expected_leds.push_back('{pwm_duty: duty_now, event_led: event_on});
   endtask

   function automatic req_word_type make_word(input action_type a, input logic [31:0] t,
                                              input logic [15:0] len, input logic [15:0] per);
      req_word_type w;
      w.action = a;
      w.time_ticks = t;
      w.blink_length = len;
      w.blink_ticks = per;
      return w;
   endfunction

   // Mostly ticks on a running clock with short blink bursts; some noise words.
   function automatic req_word_type next_random_word();
      req_word_type w;
      int unsigned pick;
      pick = $urandom_range(99);
      w.time_ticks = $urandom();
      w.blink_length = 16'($urandom());
      w.blink_ticks = 16'($urandom());
      if (pick < 82) begin
         w.action = ACT_TICK;
         if (pick >= 6) begin
            time_now = time_now + $urandom_range(1, 3);
            w.time_ticks = time_now;
         end
      end else if (pick < 94) begin
         w.action = ACT_BLINK;
         if (pick < 91) begin
            w.blink_length = 16'($urandom_range(1, 6));
            w.blink_ticks = 16'($urandom_range(2, 12));
         end
      end else if (pick < 97) begin
         w.action = ACT_SLEEP;
      end else begin
         w.action = ACT_WAKE;
      end
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_led_state(w);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_leds.size() != 0) @(posedge clock);
   endtask

   task automatic write_breath_period(input logic [15:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      breath_period = value;
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      send_word(make_word(ACT_TICK, 32'd0, 16'hFFFF, 16'hFFFF));
      send_word(make_word(ACT_TICK, 32'hFFFF_FFFF, 16'd0, 16'd0));
      send_word(make_word(ACT_TICK, 32'd4, 16'h5555, 16'hAAAA));
      // zero length and period fall back to the defaults
      send_word(make_word(ACT_BLINK, 32'hFFFF_FFFF, 16'd0, 16'd0));
      send_word(make_word(ACT_TICK, 32'd100, 16'd0, 16'd0));
      send_word(make_word(ACT_TICK, 32'd150, 16'd0, 16'd0));
      // period of one is raised to the minimum
      send_word(make_word(ACT_BLINK, 32'd0, 16'hFFFF, 16'd1));
      send_word(make_word(ACT_TICK, 32'd2, 16'd0, 16'd0));
      send_word(make_word(ACT_TICK, 32'd3, 16'd0, 16'd0));
      send_word(make_word(ACT_TICK, 32'h8000_0000, 16'd0, 16'd0));
      send_word(make_word(ACT_BLINK, 32'h1234_5678, 16'd1, 16'hFFFF));
      send_word(make_word(ACT_TICK, 32'd0, 16'd0, 16'd0));
      send_word(make_word(ACT_BLINK, 32'd0, 16'd3, 16'd3));
      send_word(make_word(ACT_TICK, 32'd3, 16'd0, 16'd0));
      send_word(make_word(ACT_TICK, 32'd4, 16'd0, 16'd0));
      send_word(make_word(ACT_TICK, 32'd6, 16'd0, 16'd0));
      send_word(make_word(ACT_SLEEP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
      send_word(make_word(ACT_TICK, 32'd8, 16'd0, 16'd0));
      send_word(make_word(ACT_WAKE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
      send_word(make_word(ACT_TICK, 32'd12, 16'd0, 16'd0));
      send_word(make_word(ACT_WAKE, 32'd0, 16'd0, 16'd0));
   endtask

   // Period below 512 leaves a zero step spacing: every tick steps.
   task automatic test_short_period();
      write_breath_period(16'd0);
      repeat (5) send_word(make_word(ACT_TICK, $urandom(), 16'd0, 16'd0));
      write_breath_period(16'd511);
      repeat (3) send_word(make_word(ACT_TICK, $urandom(), 16'd0, 16'd0));
   endtask

   // Long tick run at unit spacing: level climbs to the top and turns back.
   task automatic test_breathing_ramp();
      req_word_type w;
      write_breath_period(16'd512);
      send_idle_pct = 0;
      stall_pct = 0;
      time_now = $urandom();
      repeat (270) begin
         time_now = time_now + 32'd1;
         if ($urandom_range(19) == 0)
            w = make_word(ACT_BLINK, $urandom(), 16'($urandom_range(1, 4)),
                          16'($urandom_range(2, 8)));
         else
            w = make_word(ACT_TICK, time_now, 16'($urandom()), 16'($urandom()));
         send_word(w);
      end
   endtask

   task automatic test_random(input logic [15:0] period, input int idle_pct,
                              input int rsp_stall_pct, input int words);
      write_breath_period(period);
      send_idle_pct = idle_pct;
      stall_pct = rsp_stall_pct;
      repeat (words) send_word(next_random_word());
   endtask

   // Hold the result side off while words keep coming, so the input stalls.
   task automatic test_backpressure();
      write_breath_period(BREATH_PERIOD_RESET);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = HOLD_CYCLES;
      repeat (24) send_word(next_random_word());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_leds.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("result %0d with nothing pending: duty %0d led %0b",
                           rsp_count, rsp_word.pwm_duty, rsp_word.event_led);
            end else begin
               want = expected_leds.pop_front();
               if (rsp_word.pwm_duty !== want.pwm_duty ||
                   rsp_word.event_led !== want.event_led) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("result %0d: duty exp %0d got %0d, led exp %0b got %0b",
                              rsp_count, want.pwm_duty, rsp_word.pwm_duty,
                              want.event_led, rsp_word.event_led);
               end
            end
         end
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("led_breathing_and_blink_controller_tb: done, errors");
      $finish;
   end

   initial begin
      breath_period = BREATH_PERIOD_RESET;
      breathe_on = 1'b1;
      level = 8'd0;
      rising = 1'b1;
      duty_now = 10'd0;
      blinks_left = 16'd0;
      blink_per = BLINK_PER_DEFAULT;
      event_on = 1'b0;
      time_now = 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_short_period();
      test_breathing_ramp();
      test_random(16'hFFFF, 56, 0, 50);
      test_random(16'd1000, 0, 56, 50);
      test_random(16'd777, 6, 6, 60);
      test_backpressure();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += expected_leds.size();
      if (error_count == 0)
         $display("led_breathing_and_blink_controller_tb: done, clean");
      else
         $display("led_breathing_and_blink_controller_tb: done, errors");
      $finish;
   end

endmodule
